>>> rtl/pdm_pkg.sv
// Package for the pairwise dominance matrix block: sizes, data types and
// the sequencer state type. Depends on nothing; every other file uses it.
package pdm_pkg;

    localparam int MAX_OBJECTS  = 64;
    localparam int MAX_FEATURES = 8;
    localparam int VALUE_WIDTH  = 32;

    localparam int IN_WIDTH     = 32;
    localparam int INDEX_WIDTH  = 6;
    localparam int MASK_WIDTH   = 64;
    localparam int CFG_WIDTH    = 4;

    localparam int SLOT_W  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int COUNT_W = $clog2(MAX_OBJECTS + 1);
    localparam int NF_W    = $clog2(MAX_FEATURES + 1);

    typedef logic signed [IN_WIDTH-1:0]    feature_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef value_t [MAX_FEATURES-1:0]     row_t;
    typedef logic [MAX_OBJECTS-1:0]        obj_mask_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/pdm_if.sv
// Handshake interfaces for the item and result channels of the pairwise
// dominance matrix block. Depends on pdm_pkg.
interface pdm_item_if;
    logic                valid;
    logic                ready;
    logic                start_set;
    pdm_pkg::feature_t   feature_0;
    pdm_pkg::feature_t   feature_1;
    pdm_pkg::feature_t   feature_2;
    pdm_pkg::feature_t   feature_3;
    pdm_pkg::feature_t   feature_4;
    pdm_pkg::feature_t   feature_5;
    pdm_pkg::feature_t   feature_6;
    pdm_pkg::feature_t   feature_7;

    modport source (
        output valid, start_set, feature_0, feature_1, feature_2, feature_3,
               feature_4, feature_5, feature_6, feature_7,
        input  ready
    );
    modport sink (
        input  valid, start_set, feature_0, feature_1, feature_2, feature_3,
               feature_4, feature_5, feature_6, feature_7,
        output ready
    );
endinterface

interface pdm_result_if;
    logic                               valid;
    logic                               ready;
    logic [pdm_pkg::INDEX_WIDTH-1:0]    object_index;
    logic [pdm_pkg::MASK_WIDTH-1:0]     dominated_mask;
    logic [pdm_pkg::MASK_WIDTH-1:0]     dominator_mask;
    logic                               overflow;

    modport source (
        output valid, object_index, dominated_mask, dominator_mask, overflow,
        input  ready
    );
    modport sink (
        input  valid, object_index, dominated_mask, dominator_mask, overflow,
        output ready
    );
endinterface

>>> rtl/pairwise_dominance_matrix.sv
// Top level of the pairwise dominance matrix block: object store, scan
// sequencer and shared row comparator. Depends on pdm_pkg and pdm_if.
//
//   channel   direction  contents
//   item      in         start_set, feature_0 .. feature_7
//   result    out        object_index, dominated_mask, dominator_mask, overflow
//   cfg       in         cfg_we, cfg_data (features_used)
//
// With n objects already in the set, the sequencer scans those n objects,
// drains the last comparison and loads the result in its finishing step; an
// empty set or a full store goes straight to the finishing step. The next item
// can be accepted in the cycle after the result is loaded. The scan reads one
// stored object per cycle from the single read port of the object store, and
// the longest scan is over 63 stored objects.
// item.ready is high only while the sequencer is idle. A result waiting on
// result.ready does not stop the next item being accepted; the finishing step
// of that next item waits until the result register is free.
// Reset clears the object count, the sequencer and the result valid, and sets
// features_used to the full feature count; the store itself is not cleared.
module pairwise_dominance_matrix (
    input  logic                            clk,
    input  logic                            rst_n,
    pdm_item_if.sink                        item,
    pdm_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [pdm_pkg::CFG_WIDTH-1:0]   cfg_data
);

    // Object store: one row holds all features of one object as signed
    // values. Only rows below the object count are ever read.
    pdm_pkg::row_t store_mem [pdm_pkg::MAX_OBJECTS];

    pdm_pkg::state_t state_reg, state_next;

    logic [pdm_pkg::CFG_WIDTH-1:0]  features_used_reg;
    logic [pdm_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [pdm_pkg::NF_W-1:0]       nf_reg, nf_next;
    logic [pdm_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [pdm_pkg::SLOT_W-1:0]     scan_reg, scan_next;
    logic [pdm_pkg::SLOT_W-1:0]     cmp_idx_reg;
    logic                           cmp_valid_reg;
    logic                           ovf_reg, ovf_next;
    pdm_pkg::row_t                  key_reg, key_next;
    pdm_pkg::row_t                  row_reg;
    pdm_pkg::obj_mask_t             below_reg, below_next;
    pdm_pkg::obj_mask_t             above_reg, above_next;

    logic                           out_valid_reg, out_valid_next;
    logic [pdm_pkg::INDEX_WIDTH-1:0] out_index_reg;
    logic [pdm_pkg::MASK_WIDTH-1:0] out_below_reg;
    logic [pdm_pkg::MASK_WIDTH-1:0] out_above_reg;
    logic                           out_ovf_reg;

    // Decoded control from the sequencer.
    logic accept;
    logic load_result;
    logic scan_read;

    // Accept-time values.
    logic [pdm_pkg::COUNT_W-1:0]    count_eff;
    logic                           store_full;
    pdm_pkg::row_t                  fresh;
    logic [pdm_pkg::NF_W-1:0]       nf_clamped;

    // Shared comparator result for the row that was read last cycle.
    logic new_dominates;
    logic new_dominated;
    logic last_scan;

    // Each input value is cast to the comparison width with its sign kept.
    always_comb
    begin
        fresh[0] = pdm_pkg::value_t'(item.feature_0);
        if (pdm_pkg::MAX_FEATURES > 1) fresh[1 % pdm_pkg::MAX_FEATURES] =
            pdm_pkg::value_t'(item.feature_1);
        if (pdm_pkg::MAX_FEATURES > 2) fresh[2 % pdm_pkg::MAX_FEATURES] =
            pdm_pkg::value_t'(item.feature_2);
        if (pdm_pkg::MAX_FEATURES > 3) fresh[3 % pdm_pkg::MAX_FEATURES] =
            pdm_pkg::value_t'(item.feature_3);
        if (pdm_pkg::MAX_FEATURES > 4) fresh[4 % pdm_pkg::MAX_FEATURES] =
            pdm_pkg::value_t'(item.feature_4);
        if (pdm_pkg::MAX_FEATURES > 5) fresh[5 % pdm_pkg::MAX_FEATURES] =
            pdm_pkg::value_t'(item.feature_5);
        if (pdm_pkg::MAX_FEATURES > 6) fresh[6 % pdm_pkg::MAX_FEATURES] =
            pdm_pkg::value_t'(item.feature_6);
        if (pdm_pkg::MAX_FEATURES > 7) fresh[7 % pdm_pkg::MAX_FEATURES] =
            pdm_pkg::value_t'(item.feature_7);
    end

    // A feature count of zero means one; anything above the maximum means all.
    always_comb
    begin
        if (features_used_reg == '0)
            nf_clamped = pdm_pkg::NF_W'(1);
        else if (32'(features_used_reg) > pdm_pkg::MAX_FEATURES)
            nf_clamped = pdm_pkg::NF_W'(pdm_pkg::MAX_FEATURES);
        else
            nf_clamped = pdm_pkg::NF_W'(features_used_reg);
    end

    assign count_eff  = item.start_set ? '0 : count_reg;
    assign store_full = (count_eff >= pdm_pkg::COUNT_W'(pdm_pkg::MAX_OBJECTS));
    assign last_scan  = (scan_reg == slot_reg - pdm_pkg::SLOT_W'(1));

    // The shared comparator: all used features of one stored object against
    // the new object, both directions at once.
    always_comb
    begin
        new_dominates = 1'b1;
        new_dominated = 1'b1;
        for (int s = 0; s < pdm_pkg::MAX_FEATURES; s++)
        begin
            if (s < 32'(nf_reg))
            begin
                if ($signed(row_reg[s]) > $signed(key_reg[s]))
                    new_dominates = 1'b0;
                if ($signed(key_reg[s]) > $signed(row_reg[s]))
                    new_dominated = 1'b0;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdm_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (store_full || count_eff == '0)
                        state_next = pdm_pkg::ST_FINISH;
                    else
                        state_next = pdm_pkg::ST_SCAN;
                end
            end
            pdm_pkg::ST_SCAN:
            begin
                if (last_scan)
                    state_next = pdm_pkg::ST_DRAIN;
            end
            pdm_pkg::ST_DRAIN:
                state_next = pdm_pkg::ST_FINISH;
            pdm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = pdm_pkg::ST_IDLE;
            end
            default:
                state_next = pdm_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        item.ready  = 1'b0;
        scan_read   = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            pdm_pkg::ST_IDLE:   item.ready  = 1'b1;
            pdm_pkg::ST_SCAN:   scan_read   = 1'b1;
            pdm_pkg::ST_DRAIN:  scan_read   = 1'b0;
            pdm_pkg::ST_FINISH: load_result = !out_valid_reg || result.ready;
            default:            item.ready  = 1'b0;
        endcase
    end

    assign accept = item.valid && item.ready;

    // Datapath next values.
    always_comb
    begin
        count_next = count_reg;
        nf_next    = nf_reg;
        slot_next  = slot_reg;
        scan_next  = scan_reg;
        ovf_next   = ovf_reg;
        key_next   = key_reg;
        below_next = below_reg;
        above_next = above_reg;

        if (accept)
        begin
            nf_next   = nf_clamped;
            key_next  = fresh;
            scan_next = '0;
            if (store_full)
            begin
                // Dropped object: the stored set and the count stay as they were.
                count_next = count_eff;
                slot_next  = '0;
                ovf_next   = 1'b1;
                below_next = '0;
                above_next = '0;
            end
            else
            begin
                count_next = count_eff + pdm_pkg::COUNT_W'(1);
                slot_next  = count_eff[pdm_pkg::SLOT_W-1:0];
                ovf_next   = 1'b0;
                // The new object's own bit is always set in both masks.
                below_next = pdm_pkg::obj_mask_t'(1) << count_eff[pdm_pkg::SLOT_W-1:0];
                above_next = below_next;
            end
        end
        else
        begin
            if (scan_read)
                scan_next = scan_reg + pdm_pkg::SLOT_W'(1);
            if (cmp_valid_reg)
            begin
                if (new_dominates)
                    below_next[cmp_idx_reg] = 1'b1;
                if (new_dominated)
                    above_next[cmp_idx_reg] = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (load_result)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= pdm_pkg::ST_IDLE;
            features_used_reg <= pdm_pkg::CFG_WIDTH'(pdm_pkg::MAX_FEATURES);
            count_reg         <= '0;
            cmp_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= scan_read;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                features_used_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        nf_reg      <= nf_next;
        slot_reg    <= slot_next;
        scan_reg    <= scan_next;
        ovf_reg     <= ovf_next;
        key_reg     <= key_next;
        below_reg   <= below_next;
        above_reg   <= above_next;
        cmp_idx_reg <= scan_reg;
        if (load_result)
        begin
            out_index_reg <= pdm_pkg::INDEX_WIDTH'(slot_reg);
            out_below_reg <= pdm_pkg::MASK_WIDTH'(below_reg);
            out_above_reg <= pdm_pkg::MASK_WIDTH'(above_reg);
            out_ovf_reg   <= ovf_reg;
        end
    end

    // Store write happens on an accept unless the store is full; the scan never reads the slot being
    // written, and it never runs in the same cycle as an accept.
    always_ff @(posedge clk)
    begin
        if (accept && !store_full)
            store_mem[count_eff[pdm_pkg::SLOT_W-1:0]] <= fresh;
        if (scan_read)
            row_reg <= store_mem[scan_reg];
    end

    assign result.valid          = out_valid_reg;
    assign result.object_index   = out_index_reg;
    assign result.dominated_mask = out_below_reg;
    assign result.dominator_mask = out_above_reg;
    assign result.overflow       = out_ovf_reg;

endmodule

>>> rtl/pdm_checker.sv
// Port-level checker for the pairwise dominance matrix block, with the bind
// that attaches it to the top level. Depends on pdm_pkg.
module pdm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_ready,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [pdm_pkg::INDEX_WIDTH-1:0]  object_index,
    input logic [pdm_pkg::MASK_WIDTH-1:0]   dominated_mask,
    input logic [pdm_pkg::MASK_WIDTH-1:0]   dominator_mask,
    input logic                             overflow
);

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(object_index)
            && $stable(dominated_mask) && $stable(dominator_mask) && $stable(overflow))
        else $error("stalled result changed");

    // The block works on one object at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while the previous one is in progress");

    // The new object's own bit is set in both masks.
    a_own_bit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !overflow |->
            dominated_mask[object_index] && dominator_mask[object_index])
        else $error("own bit missing from a mask");

    // A dropped object reports nothing but the overflow flag.
    a_overflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && overflow |->
            object_index == '0 && dominated_mask == '0 && dominator_mask == '0)
        else $error("overflow result carries data");

endmodule

bind pairwise_dominance_matrix pdm_checker u_pdm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .object_index   (result.object_index),
    .dominated_mask (result.dominated_mask),
    .dominator_mask (result.dominator_mask),
    .overflow       (result.overflow)
);
